// File: rtl/core/qcsd_pkg.sv
package qcsd_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int JUMP_LIMIT  = 50000;

   localparam int WORD_W  = 32;
   localparam int SCALE_W = 40;
   localparam int FRAC_W  = 16;
   localparam int INT_W   = SCALE_W - FRAC_W;
   localparam int WIDE_W  = (COUNT_WIDTH > WORD_W) ? COUNT_WIDTH : WORD_W;

   // magnitude bits needed for a difference that is inside the jump limit
   localparam int LIMIT_W = $clog2(JUMP_LIMIT + 1);
   localparam int MAG_W   = (LIMIT_W < COUNT_WIDTH) ? LIMIT_W : COUNT_WIDTH;

   localparam int HI_PROD_W = MAG_W + INT_W;
   localparam int LO_PROD_W = MAG_W + FRAC_W;
   localparam int SUM_W     = HI_PROD_W + 1;
   localparam int SAT_W     = (SUM_W > WORD_W + 1) ? SUM_W : WORD_W + 1;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 40'd23592960;
   localparam logic [WORD_W-1:0]  SPEED_MAX   = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0]  SPEED_MIN   = 32'h8000_0000;

   typedef enum logic [2:0] {
      MODE_EDGE       = 3'd0,
      MODE_SPEED      = 3'd1,
      MODE_DIST_READ  = 3'd2,
      MODE_RT_READ    = 3'd3,
      MODE_DIST_CLEAR = 3'd4
   } mode_type;

   // result of the tracking stage, on its way to the speed arithmetic
   typedef struct packed {
      logic [WORD_W-1:0] position;
      logic [WORD_W-1:0] distance;
      logic              speed_op;
      logic              held;
      logic              neg;
      logic [MAG_W-1:0]  mag;
   } track_type;

   function automatic logic [WORD_W-1:0] count_word(input logic [COUNT_WIDTH-1:0] v);
      logic [WIDE_W-1:0] t;
      t = WIDE_W'(v);
      return t[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] diff_word(input logic [COUNT_WIDTH-1:0] v);
      logic signed [WIDE_W-1:0] t;
      t = WIDE_W'(signed'(v));
      return t[WORD_W-1:0];
   endfunction

endpackage

// File: rtl/core/qcsd_track.sv
module qcsd_track (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_mode,
   input  logic                req_a_level,
   input  logic                req_b_level,
   input  logic                p1_take,
   output logic                p1_valid,
   output qcsd_pkg::track_type p1_data
);
   import qcsd_pkg::*;

   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [COUNT_WIDTH-1:0] speed_snap_ff, speed_snap_in;
   logic [COUNT_WIDTH-1:0] rt_snap_ff, rt_snap_in;
   logic [WORD_W-1:0]      dist_total_ff, dist_total_in;
   logic                   p1_valid_ff, p1_valid_in;
   track_type              p1_ff, p1_in;

   logic                   accept;
   logic [COUNT_WIDTH-1:0] d_speed, d_rt, d_mag;
   logic [WORD_W-1:0]      dist_sum;
   logic                   d_neg, in_range;

   assign req_stall = p1_valid_ff & ~p1_take;
   assign accept    = req_valid & ~req_stall;
   assign p1_valid  = p1_valid_ff;
   assign p1_data   = p1_ff;

   assign d_speed  = tick_ff - speed_snap_ff;
   assign d_rt     = tick_ff - rt_snap_ff;
   assign d_neg    = d_speed[COUNT_WIDTH-1];
   assign d_mag    = d_neg ? (~d_speed + COUNT_WIDTH'(1)) : d_speed;
   assign in_range = WIDE_W'(d_mag) < WIDE_W'(JUMP_LIMIT);
   assign dist_sum = dist_total_ff + diff_word(d_speed);

   always_comb begin
      tick_in       = tick_ff;
      speed_snap_in = speed_snap_ff;
      rt_snap_in    = rt_snap_ff;
      dist_total_in = dist_total_ff;
      p1_in.distance = '0;
      p1_in.speed_op = 1'b0;
      p1_in.held     = 1'b0;
      p1_in.neg      = d_neg;
      p1_in.mag      = d_mag[MAG_W-1:0];
      unique case (mode_type'(req_mode))
         MODE_EDGE: begin
            // levels that differ step forward, matching levels step back
            if (req_a_level != req_b_level) begin
               tick_in = tick_ff + COUNT_WIDTH'(1);
            end else begin
               tick_in = tick_ff - COUNT_WIDTH'(1);
            end
         end
         MODE_SPEED: begin
            speed_snap_in  = tick_ff;
            dist_total_in  = dist_sum;
            p1_in.speed_op = 1'b1;
            p1_in.held     = ~in_range;
         end
         MODE_DIST_READ: begin
            speed_snap_in  = tick_ff;
            dist_total_in  = '0;
            p1_in.distance = dist_sum;
         end
         MODE_RT_READ: begin
            rt_snap_in     = tick_ff;
            p1_in.distance = diff_word(d_rt);
         end
         MODE_DIST_CLEAR: begin
            dist_total_in = '0;
         end
         default: begin
         end
      endcase
      p1_in.position = count_word(tick_in);
      p1_valid_in    = accept | (p1_valid_ff & ~p1_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         speed_snap_ff <= '0;
         rt_snap_ff    <= '0;
         dist_total_ff <= '0;
         p1_valid_ff   <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
         if (accept) begin
            tick_ff       <= tick_in;
            speed_snap_ff <= speed_snap_in;
            rt_snap_ff    <= rt_snap_in;
            dist_total_ff <= dist_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_ff <= p1_in;
      end
   end

endmodule

// File: rtl/core/qcsd_speed.sv
module qcsd_speed (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [qcsd_pkg::SCALE_W-1:0]       csr_wr_data,
   input  logic                               p1_valid,
   input  qcsd_pkg::track_type                p1_data,
   output logic                               p1_take,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qcsd_pkg::WORD_W-1:0] rsp_position_count,
   output logic signed [qcsd_pkg::WORD_W-1:0] rsp_speed_value,
   output logic signed [qcsd_pkg::WORD_W-1:0] rsp_distance_ticks,
   output logic                               rsp_speed_held
);
   import qcsd_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0]    position;
      logic [WORD_W-1:0]    distance;
      logic                 speed_op;
      logic                 held;
      logic                 neg;
      logic [HI_PROD_W-1:0] prod_hi;
      logic [LO_PROD_W-1:0] prod_lo;
   } mult_type;

   logic [SCALE_W-1:0] scale_ff;
   logic               p2_valid_ff, p2_valid_in;
   mult_type           p2_ff, p2_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  last_speed_ff, last_speed_in;
   logic [WORD_W-1:0]  position_ff, distance_ff, speed_ff, speed_in;
   logic               held_ff;

   logic               p2_take, out_take, p2_load, out_load;
   logic [SUM_W-1:0]   prod;
   logic [SAT_W-1:0]   prod_wide;
   logic               over;
   logic [WORD_W-1:0]  sat_speed;

   assign out_take = ~rsp_valid_ff | ~rsp_stall;
   assign p2_take  = ~p2_valid_ff | out_take;
   assign p1_take  = p2_take;
   assign p2_load  = p1_valid & p2_take;
   assign out_load = p2_valid_ff & out_take;

   assign p2_valid_in  = p2_take ? p1_valid : p2_valid_ff;
   assign rsp_valid_in = out_take ? p2_valid_ff : rsp_valid_ff;

   always_comb begin
      p2_in.position = p1_data.position;
      p2_in.distance = p1_data.distance;
      p2_in.speed_op = p1_data.speed_op;
      p2_in.held     = p1_data.held;
      p2_in.neg      = p1_data.neg;
      p2_in.prod_hi  = HI_PROD_W'(p1_data.mag) * HI_PROD_W'(scale_ff[SCALE_W-1:FRAC_W]);
      p2_in.prod_lo  = LO_PROD_W'(p1_data.mag) * LO_PROD_W'(scale_ff[FRAC_W-1:0]);
   end

   // integer part plus the truncated fractional contribution
   assign prod      = SUM_W'(p2_ff.prod_hi) + SUM_W'(p2_ff.prod_lo[LO_PROD_W-1:FRAC_W]);
   assign prod_wide = SAT_W'(prod);
   assign over      = |prod_wide[SAT_W-1:WORD_W-1];

   always_comb begin
      if (p2_ff.neg) begin
         sat_speed = over ? SPEED_MIN : (~prod_wide[WORD_W-1:0] + WORD_W'(1));
      end else begin
         sat_speed = over ? SPEED_MAX : prod_wide[WORD_W-1:0];
      end
      if (p2_ff.speed_op & ~p2_ff.held) begin
         speed_in = sat_speed;
      end else begin
         speed_in = last_speed_ff;
      end
      last_speed_in = out_load ? speed_in : last_speed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= SCALE_RESET;
         p2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_speed_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
         p2_valid_ff   <= p2_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         last_speed_ff <= last_speed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_load) begin
         p2_ff <= p2_in;
      end
      if (out_load) begin
         position_ff <= p2_ff.position;
         distance_ff <= p2_ff.distance;
         speed_ff    <= speed_in;
         held_ff     <= p2_ff.held;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_count = signed'(position_ff);
   assign rsp_speed_value    = signed'(speed_ff);
   assign rsp_distance_ticks = signed'(distance_ff);
   assign rsp_speed_held     = held_ff;

endmodule

// File: rtl/core/quadrature_counter_speed_distance.sv
// pipeline: an accepted transaction passes through the tracking, multiply and saturate stage
//   registers in that order, and the saturate stage registers drive the outputs
// throughput: one transaction per cycle while the receiver does not stall; tracking, multiply and
//   saturate stages are each one register deep, and each stage holds while the next one is stalled
// reset: synchronous, active high; clears count, snapshots, distance and held speed,
//   loads speed_scale with 360.0 and empties the pipeline
module quadrature_counter_speed_distance (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_mode,
   input  logic                               req_a_level,
   input  logic                               req_b_level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [qcsd_pkg::WORD_W-1:0] rsp_position_count,
   output logic signed [qcsd_pkg::WORD_W-1:0] rsp_speed_value,
   output logic signed [qcsd_pkg::WORD_W-1:0] rsp_distance_ticks,
   output logic                               rsp_speed_held,
   input  logic                               csr_wr_en,
   input  logic [qcsd_pkg::SCALE_W-1:0]       csr_wr_data
);
   import qcsd_pkg::*;

   logic      p1_valid, p1_take;
   track_type p1_data;

   qcsd_track u_track (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_mode    (req_mode),
      .req_a_level (req_a_level),
      .req_b_level (req_b_level),
      .p1_take     (p1_take),
      .p1_valid    (p1_valid),
      .p1_data     (p1_data)
   );

   qcsd_speed u_speed (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .p1_valid           (p1_valid),
      .p1_data            (p1_data),
      .p1_take            (p1_take),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position_count (rsp_position_count),
      .rsp_speed_value    (rsp_speed_value),
      .rsp_distance_ticks (rsp_distance_ticks),
      .rsp_speed_held     (rsp_speed_held)
   );

endmodule

// File: rtl/core/qcsd_checker.sv
module qcsd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [2:0]                         req_mode,
   input logic                               req_a_level,
   input logic                               req_b_level,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [qcsd_pkg::WORD_W-1:0] rsp_position_count,
   input logic signed [qcsd_pkg::WORD_W-1:0] rsp_speed_value,
   input logic signed [qcsd_pkg::WORD_W-1:0] rsp_distance_ticks,
   input logic                               rsp_speed_held,
   input logic                               csr_wr_en,
   input logic [qcsd_pkg::SCALE_W-1:0]       csr_wr_data
);
   import qcsd_pkg::*;

   // pipeline is empty straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held speed comes from a speed sample, which carries no distance
   a_held_no_distance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_speed_held) |-> (rsp_distance_ticks == '0))
      else $error("held speed with non-zero distance");

   // a held speed repeats the speed of the transaction just before it
   a_held_repeats: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1 (rsp_valid && rsp_speed_held)
      |-> (rsp_speed_value == $past(rsp_speed_value)))
      else $error("held speed differs from previous speed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_position_count)
      && $stable(rsp_speed_value) && $stable(rsp_distance_ticks)
      && $stable(rsp_speed_held)))
      else $error("stalled result changed");

endmodule

bind quadrature_counter_speed_distance qcsd_checker u_qcsd_checker (.*);

// File: sim/qcsd_reading_checker.sv
`timescale 1ns / 1ps

module qcsd_reading_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [2:0]                         req_mode,
   input  logic                               req_a_level,
   input  logic                               req_b_level,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [qcsd_pkg::WORD_W-1:0] rsp_position_count,
   input  logic signed [qcsd_pkg::WORD_W-1:0] rsp_speed_value,
   input  logic signed [qcsd_pkg::WORD_W-1:0] rsp_distance_ticks,
   input  logic                               rsp_speed_held,
   input  logic                               csr_wr_en,
   input  logic [qcsd_pkg::SCALE_W-1:0]       csr_wr_data,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 readings_checked,
   output int                                 held_readings
);
   import qcsd_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] position;
      logic [WORD_W-1:0] speed;
      logic [WORD_W-1:0] distance;
      logic              held;
   } reading_type;

   logic [SCALE_W-1:0]     scale;
   logic [COUNT_WIDTH-1:0] ticks;
   logic [COUNT_WIDTH-1:0] speed_snap;
   logic [COUNT_WIDTH-1:0] rt_snap;
   logic [WORD_W-1:0]      dist_total;
   logic [WORD_W-1:0]      held_speed;
   reading_type            readings_due[$];

   // exact product of tick difference and Q24.16 scale, truncated toward zero and saturated
   function automatic logic [WORD_W-1:0] signed_speed(input logic signed [63:0] diff);
      logic [63:0] mag;
      logic [63:0] prod;
      mag  = diff[63] ? 64'(-diff) : 64'(diff);
      prod = mag * 64'(scale[SCALE_W-1:FRAC_W])
             + ((mag * 64'(scale[FRAC_W-1:0])) >> FRAC_W);
      if (diff[63]) begin
         if (prod >= 64'h8000_0000)
            return SPEED_MIN;
         return WORD_W'(~prod + 64'd1);
      end
      if (prod > 64'h7FFF_FFFF)
         return SPEED_MAX;
      return prod[WORD_W-1:0];
   endfunction

   task automatic advance_encoder(input logic [2:0] m, input logic a, input logic b,
                                  output reading_type r);
      logic signed [COUNT_WIDTH-1:0] diff;
      logic signed [63:0]            wide;
      logic [63:0]                   mag;
      r.speed    = held_speed;
      r.distance = '0;
      r.held     = 1'b0;
      case (m)
         MODE_EDGE: ticks = (a != b) ? ticks + COUNT_WIDTH'(1) : ticks - COUNT_WIDTH'(1);
         MODE_SPEED: begin
            diff       = ticks - speed_snap;
            wide       = 64'(diff);
            speed_snap = ticks;
            dist_total = dist_total + wide[WORD_W-1:0];
            mag        = wide[63] ? 64'(-wide) : 64'(wide);
            if (mag < 64'(JUMP_LIMIT)) begin
               held_speed = signed_speed(wide);
               r.speed    = held_speed;
            end else begin
               r.held = 1'b1;
            end
         end
         MODE_DIST_READ: begin
            diff       = ticks - speed_snap;
            wide       = 64'(diff);
            speed_snap = ticks;
            dist_total = dist_total + wide[WORD_W-1:0];
            r.distance = dist_total;
            dist_total = '0;
         end
         MODE_RT_READ: begin
            diff       = ticks - rt_snap;
            wide       = 64'(diff);
            rt_snap    = ticks;
            r.distance = wide[WORD_W-1:0];
         end
         MODE_DIST_CLEAR: dist_total = '0;
         default: ;
      endcase
      r.position = WORD_W'(ticks);
   endtask

   task automatic compare_field(input string field, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d",
                  $time, field, $signed(want), $signed(got));
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      reading_type fresh;
      if (reset) begin
         scale      = SCALE_RESET;
         ticks      = '0;
         speed_snap = '0;
         rt_snap    = '0;
         dist_total = '0;
         held_speed = '0;
         readings_due.delete();
      end else begin
         if (csr_wr_en)
            scale = csr_wr_data;
         if (req_valid && !req_stall) begin
            advance_encoder(req_mode, req_a_level, req_b_level, fresh);
            readings_due.push_back(fresh);
         end
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               fail_count++;
               $display("%0t ns: reading with no transaction outstanding, position %0d",
                        $time, rsp_position_count);
            end else begin
               want = readings_due.pop_front();
               readings_checked++;
               if (want.held)
                  held_readings++;
               compare_field("position_count", want.position, rsp_position_count);
               compare_field("speed_value", want.speed, rsp_speed_value);
               compare_field("distance_ticks", want.distance, rsp_distance_ticks);
               compare_field("speed_held", WORD_W'(want.held), WORD_W'(rsp_speed_held));
            end
         end
      end
      pending = readings_due.size();
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import qcsd_pkg::*;

   localparam logic [2:0] FIRST_UNUSED_MODE = 3'd5;
   localparam logic [2:0] LAST_UNUSED_MODE  = 3'd7;
   localparam int         IDLE_LIMIT        = 2000;
   localparam int         PHASE_ITEMS       = 230;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic [2:0]                req_mode    = MODE_EDGE;
   logic                      req_a_level = 1'b0;
   logic                      req_b_level = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic signed [WORD_W-1:0]  rsp_position_count;
   logic signed [WORD_W-1:0]  rsp_speed_value;
   logic signed [WORD_W-1:0]  rsp_distance_ticks;
   logic                      rsp_speed_held;
   logic                      csr_wr_en   = 1'b0;
   logic [SCALE_W-1:0]        csr_wr_data = '0;

   int fail_count;
   int pending;
   int readings_checked;
   int held_readings;
   int items_sent  = 0;
   int scale_writes = 0;
   int burst_left  = 0;
   int stall_pct   = 0;
   int stall_left  = 0;
   int idle_cycles = 0;

   always #2 clock = ~clock;

   quadrature_counter_speed_distance DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_a_level        (req_a_level),
      .req_b_level        (req_b_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position_count (rsp_position_count),
      .rsp_speed_value    (rsp_speed_value),
      .rsp_distance_ticks (rsp_distance_ticks),
      .rsp_speed_held     (rsp_speed_held),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   qcsd_reading_checker reading_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_a_level        (req_a_level),
      .req_b_level        (req_b_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_position_count (rsp_position_count),
      .rsp_speed_value    (rsp_speed_value),
      .rsp_distance_ticks (rsp_distance_ticks),
      .rsp_speed_held     (rsp_speed_held),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .fail_count         (fail_count),
      .pending            (pending),
      .readings_checked   (readings_checked),
      .held_readings      (held_readings)
   );

   // receiver backpressure: the stall density is redrawn from 0, 20, 50 or 85 percent when its hold count runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_left <= $urandom_range(20, 300);
         case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 20;
            2: stall_pct <= 50;
            default: stall_pct <= 85;
         endcase
      end else begin
         stall_left <= stall_left - 1;
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   // called just after a rising edge, returns just after the accepting edge
   task automatic send_item(input logic [2:0] m, input logic a, input logic b);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 30);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_mode    <= m;
      req_a_level <= a;
      req_b_level <= b;
      @(negedge clock);
      while (req_stall)
         @(negedge clock);
      @(posedge clock);
      items_sent++;
   endtask

   task automatic edge_step(input bit up);
      logic a;
      a = coin();
      send_item(MODE_EDGE, a, up ? ~a : a);
   endtask

   task automatic edge_run(input int n, input bit up);
      repeat (n) edge_step(up);
   endtask

   task automatic drain_readings();
      req_valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_scale(input logic [SCALE_W-1:0] value);
      drain_readings();
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      scale_writes++;
   endtask

   // edge runs with a drift, each closed by a snapshot, read, clear, unused mode or single edge
   task automatic random_phase(input int n_items);
      int target;
      int pct_up;
      int run;
      int pick;
      target = items_sent + n_items;
      pct_up = $urandom_range(10, 90);
      while (items_sent < target) begin
         run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
         repeat (run) edge_step($urandom_range(1, 100) <= pct_up);
         pick = $urandom_range(0, 99);
         if (pick < 45)
            send_item(MODE_SPEED, coin(), coin());
         else if (pick < 60)
            send_item(MODE_DIST_READ, coin(), coin());
         else if (pick < 75)
            send_item(MODE_RT_READ, coin(), coin());
         else if (pick < 85)
            send_item(MODE_DIST_CLEAR, coin(), coin());
         else if (pick < 93)
            send_item(3'($urandom_range(FIRST_UNUSED_MODE, LAST_UNUSED_MODE)),
                      coin(), coin());
         else
            send_item(MODE_EDGE, coin(), coin());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // both level pairs in each direction, then positive, zero and negative speeds, reads, clear and unused modes
      send_item(MODE_EDGE, 1'b0, 1'b0);
      send_item(MODE_EDGE, 1'b1, 1'b1);
      send_item(MODE_EDGE, 1'b0, 1'b1);
      send_item(MODE_EDGE, 1'b1, 1'b0);
      edge_run(3, 1'b1);
      send_item(MODE_SPEED, 1'b0, 1'b0);
      send_item(MODE_SPEED, 1'b1, 1'b1);
      edge_run(2, 1'b0);
      send_item(MODE_SPEED, 1'b0, 1'b1);
      send_item(MODE_RT_READ, 1'b0, 1'b0);
      send_item(MODE_RT_READ, 1'b1, 1'b1);
      send_item(MODE_DIST_READ, 1'b0, 1'b0);
      send_item(MODE_DIST_READ, 1'b1, 1'b0);
      edge_run(1, 1'b1);
      send_item(MODE_SPEED, 1'b0, 1'b0);
      send_item(MODE_DIST_CLEAR, 1'b1, 1'b1);
      send_item(MODE_DIST_READ, 1'b0, 1'b0);
      for (int m = FIRST_UNUSED_MODE; m <= LAST_UNUSED_MODE; m++)
         send_item(m[2:0], 1'b1, 1'b1);

      // full-scale setting saturates both ways
      write_scale('1);
      edge_run(150, 1'b1);
      send_item(MODE_SPEED, 1'b0, 1'b0);
      edge_run(300, 1'b0);
      send_item(MODE_SPEED, 1'b0, 1'b0);
      random_phase(PHASE_ITEMS);

      write_scale('0);
      random_phase(PHASE_ITEMS);
      write_scale(SCALE_W'(1) << FRAC_W);
      random_phase(PHASE_ITEMS);
      write_scale(SCALE_W'({$urandom, $urandom}));
      random_phase(PHASE_ITEMS);
      write_scale(SCALE_W'($urandom_range(1, 32'h00FF_FFFF)));
      random_phase(PHASE_ITEMS);
      write_scale(SCALE_RESET);
      random_phase(PHASE_ITEMS);

      drain_readings();
      repeat (10) @(posedge clock);
      $display("sent %0d transactions under %0d speed scale settings, saturating both ways",
               items_sent, scale_writes + 1);
      $display("compared %0d readings, %0d of them with the speed held", readings_checked,
               held_readings);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
